>>> rtl/prpp_pkg.sv
// Package with the shared constants, types and helpers of the point rotate and plot core.
`default_nettype none
package prpp_pkg;
  localparam int GridRows = 50;
  localparam int GridCols = 60;
  localparam int CoordW = 16;
  localparam int CfgW = 16;
  localparam int GlyphW = 8;
  localparam int CellW = 6;
  localparam int RotW = 24;
  localparam int ProdW = 40;
  localparam int SumW = 48;
  localparam int QuoW = CellW;
  localparam int DenW = 22;
  localparam int NumW = DenW + QuoW;
  localparam int Stages = 8;

  typedef enum logic {
    CFG_COSINE = 1'b0,
    CFG_SINE   = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [QuoW-1:0] quo;
    logic [NumW-1:0] rem;
  } div_t;

  function automatic logic signed [RotW-1:0] to_q12(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] t;
    begin
      t = v + 48'sd8192;
      to_q12 = RotW'(t >>> 14);
    end
  endfunction

  // Restoring division steps for quotient bits hi down to lo.
  function automatic div_t div_steps(input div_t a, input logic [DenW-1:0] den,
                                     input int hi, input int lo);
    div_t r;
    logic [NumW-1:0] dsh;
    begin
      r = a;
      for (int i = hi; i >= lo; i--) begin
        dsh = NumW'(den) << i;
        if (r.rem >= dsh) begin
          r.rem = r.rem - dsh;
          r.quo[i] = 1'b1;
        end
      end
      div_steps = r;
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/point_rotate_project_plot_core.sv
// Top level of the point rotate, project and plot core.
// Throughput one point per cycle while the result is not stalled.
// The path is three rotation stages, an offset stage, a scale stage and three divide stages.
// A stalled result holds every stage and stalls the input in the same cycle.
// Reset clears the valid bits and sets cosine to one and sine to zero.
`default_nettype none
module point_rotate_project_plot_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [prpp_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic signed [prpp_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [prpp_pkg::CoordW-1:0] point_y_i,
  input  wire logic signed [prpp_pkg::CoordW-1:0] point_z_i,
  input  wire logic [prpp_pkg::GlyphW-1:0] glyph_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [prpp_pkg::CellW-1:0] row_o,
  output logic [prpp_pkg::CellW-1:0] column_o,
  output logic [prpp_pkg::GlyphW-1:0] plot_glyph_o,
  output logic drawn_o
);
  import prpp_pkg::*;
  logic signed [CfgW-1:0] cos_q, sin_q;
  logic [Stages-1:0] v_q;
  logic en;
  logic signed [RotW-1:0] y0_q, z1, x1, x2, y2, y3, z3;
  logic signed [RotW-1:0] z_q2, x_q3;
  logic [GlyphW-1:0] g_q [Stages-1];
  logic signed [RotW-1:0] w_d, sx_d, sy_d;
  logic signed [RotW-1:0] w_q, sx_q, sy_q;
  logic [RotW-1:0] ax_d, ay_d, aw_d;
  logic [NumW-1:0] num_d [2];
  logic [NumW-1:0] num_q [2];
  logic [DenW-1:0] den5_q, den6_q, den7_q;
  logic [1:0] neg_d, neg5_q, neg6_q, neg7_q;
  logic wz5_q, wz6_q, wz7_q;
  div_t d6_d [2];
  div_t d6_q [2];
  div_t d7_d [2];
  div_t d7_q [2];
  div_t d8_d [2];
  logic [1:0] ovf6_d, ovf6_q, ovf7_q;
  logic [1:0] fit_d;
  logic ok_d;
  logic [CellW-1:0] r_q, k_q;
  logic dr_q;

  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= 16'sd16384;
      sin_q <= '0;
      v_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_COSINE) cos_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_SINE) sin_q <= cfg_data_i;
      if (en) v_q <= {v_q[Stages-2:0], in_valid_i};
    end
  end
  assign out_valid_o = v_q[Stages-1];

  // About Y: a=z, b=x gives z'=z*c-x*s, x'=z*s+x*c.
  prpp_rotate u_rot_y (.clk_i, .en_i(en), .a_i(RotW'(point_z_i)), .b_i(RotW'(point_x_i)),
    .c_i(cos_q), .s_i(sin_q), .a_o(z1), .b_o(x1));
  always_ff @(posedge clk_i) if (en) begin
    y0_q <= RotW'(point_y_i);
    g_q[0] <= glyph_i;
  end
  // About Z: a=x, b=y.
  prpp_rotate u_rot_z (.clk_i, .en_i(en), .a_i(x1), .b_i(y0_q),
    .c_i(cos_q), .s_i(sin_q), .a_o(x2), .b_o(y2));
  always_ff @(posedge clk_i) if (en) begin
    z_q2 <= z1;
    g_q[1] <= g_q[0];
  end
  // About X: a=y, b=z.
  prpp_rotate u_rot_x (.clk_i, .en_i(en), .a_i(y2), .b_i(z_q2),
    .c_i(cos_q), .s_i(sin_q), .a_o(y3), .b_o(z3));
  always_ff @(posedge clk_i) if (en) begin
    x_q3 <= x2;
    g_q[2] <= g_q[1];
  end

  assign w_d = z3 + RotW'(4096);
  assign sx_d = x_q3 + w_d;
  assign sy_d = y3 + w_d;
  always_ff @(posedge clk_i) if (en) begin
    w_q <= w_d;
    sx_q <= sx_d;
    sy_q <= sy_d;
    g_q[3] <= g_q[2];
  end

  // The rounded quotient is floor((|n| + |w|) / (2|w|)) with the sign of n times w.
  always_comb begin
    ax_d = sx_q[RotW-1] ? RotW'(-sx_q) : sx_q;
    ay_d = sy_q[RotW-1] ? RotW'(-sy_q) : sy_q;
    aw_d = w_q[RotW-1] ? RotW'(-w_q) : w_q;
    num_d[0] = NumW'(ax_d) * NumW'(GridRows) + NumW'(aw_d);
    num_d[1] = NumW'(ay_d) * NumW'(GridCols) + NumW'(aw_d);
    neg_d[0] = (sx_q != '0) && (sx_q[RotW-1] != w_q[RotW-1]);
    neg_d[1] = (sy_q != '0) && (sy_q[RotW-1] != w_q[RotW-1]);
  end
  always_ff @(posedge clk_i) if (en) begin
    num_q[0] <= num_d[0];
    num_q[1] <= num_d[1];
    den5_q <= DenW'({aw_d, 1'b0});
    neg5_q <= neg_d;
    wz5_q <= (w_q == '0);
    g_q[4] <= g_q[3];
  end

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      ovf6_d[ch] = num_q[ch] >= (NumW'(den5_q) << QuoW);
      d6_d[ch] = div_steps({{QuoW{1'b0}}, num_q[ch]}, den5_q, QuoW - 1, QuoW - 2);
    end
  end
  always_ff @(posedge clk_i) if (en) begin
    d6_q[0] <= d6_d[0];
    d6_q[1] <= d6_d[1];
    ovf6_q <= ovf6_d;
    den6_q <= den5_q;
    neg6_q <= neg5_q;
    wz6_q <= wz5_q;
    g_q[5] <= g_q[4];
  end

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      d7_d[ch] = div_steps(d6_q[ch], den6_q, QuoW - 3, 1);
    end
  end
  always_ff @(posedge clk_i) if (en) begin
    d7_q[0] <= d7_d[0];
    d7_q[1] <= d7_d[1];
    ovf7_q <= ovf6_q;
    den7_q <= den6_q;
    neg7_q <= neg6_q;
    wz7_q <= wz6_q;
    g_q[6] <= g_q[5];
  end

  always_comb begin
    d8_d[0] = div_steps(d7_q[0], den7_q, 0, 0);
    d8_d[1] = div_steps(d7_q[1], den7_q, 0, 0);
    fit_d[0] = !ovf7_q[0] && (neg7_q[0] ? (d8_d[0].quo == '0)
                                        : (d8_d[0].quo < CellW'(GridRows)));
    fit_d[1] = !ovf7_q[1] && (neg7_q[1] ? (d8_d[1].quo == '0)
                                        : (d8_d[1].quo < CellW'(GridCols)));
    ok_d = !wz7_q && fit_d[0] && fit_d[1];
  end
  always_ff @(posedge clk_i) if (en) begin
    r_q <= ok_d ? d8_d[0].quo : '0;
    k_q <= ok_d ? d8_d[1].quo : '0;
    dr_q <= ok_d;
    plot_glyph_o <= ok_d ? g_q[6] : '0;
  end
  assign row_o = r_q;
  assign column_o = k_q;
  assign drawn_o = dr_q;

  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drawn_o |-> (row_o < GridRows && column_o < GridCols))
    else $error("cell off grid");
  a_nodraw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drawn_o |-> (row_o == 0 && column_o == 0))
    else $error("undrawn cell not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable({row_o, column_o, plot_glyph_o, drawn_o}))
    else $error("stalled result moved");
endmodule
`default_nettype wire

>>> rtl/prpp_rotate.sv
// One rotation stage: two product sums rounded back to Q.12, registered.
`default_nettype none
module prpp_rotate (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic signed [prpp_pkg::RotW-1:0] a_i,
  input  wire logic signed [prpp_pkg::RotW-1:0] b_i,
  input  wire logic signed [prpp_pkg::CfgW-1:0] c_i,
  input  wire logic signed [prpp_pkg::CfgW-1:0] s_i,
  output logic signed [prpp_pkg::RotW-1:0] a_o,
  output logic signed [prpp_pkg::RotW-1:0] b_o
);
  import prpp_pkg::*;
  logic signed [ProdW-1:0] ac_d, bs_d, as_d, bc_d;
  logic signed [SumW-1:0] pa_d;
  logic signed [SumW-1:0] pb_d;
  always_comb begin
    ac_d = ProdW'(a_i) * ProdW'(c_i);
    bs_d = ProdW'(b_i) * ProdW'(s_i);
    as_d = ProdW'(a_i) * ProdW'(s_i);
    bc_d = ProdW'(b_i) * ProdW'(c_i);
    pa_d = SumW'(ac_d) - SumW'(bs_d);
    pb_d = SumW'(as_d) + SumW'(bc_d);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= to_q12(pa_d);
      b_o <= to_q12(pb_d);
    end
  end
endmodule
`default_nettype wire

>>> bench/tb_point_rotate_project_plot_core.sv
// Self-checking testbench for the point rotate, project and plot core.
`timescale 1ns / 1ps
module tb_point_rotate_project_plot_core;
  import prpp_pkg::*;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] column;
    logic [7:0] glyph;
    logic       drawn;
  } cell_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic signed [15:0] point_z_i = '0;
  logic [7:0] glyph_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [5:0] row_o;
  logic [5:0] column_o;
  logic [7:0] plot_glyph_o;
  logic drawn_o;

  point_rotate_project_plot_core uut (.*);

  initial forever #4 clk_i = ~clk_i;

  longint cos_q14 = 16384;
  longint sin_q14 = 0;
  cell_t expected_cells[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  function automatic longint q26_to_q12(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic cell_t project_point(logic signed [15:0] px, logic signed [15:0] py,
                                          logic signed [15:0] pz, logic [7:0] g);
    longint x, y, z, nx, ny, nz, w, r, k;
    cell_t res;
    x = px;
    y = py;
    z = pz;
    res = '0;
    nx = q26_to_q12(x * cos_q14 + z * sin_q14);
    nz = q26_to_q12(z * cos_q14 - x * sin_q14);
    x = nx;
    z = nz;
    nx = q26_to_q12(x * cos_q14 - y * sin_q14);
    ny = q26_to_q12(x * sin_q14 + y * cos_q14);
    x = nx;
    y = ny;
    ny = q26_to_q12(y * cos_q14 - z * sin_q14);
    nz = q26_to_q12(y * sin_q14 + z * cos_q14);
    y = ny;
    z = nz;
    w = z + 4096;
    if (w != 0) begin
      r = round_div((x + w) * GridRows, 2 * w);
      k = round_div((y + w) * GridCols, 2 * w);
      if (r >= 0 && r < GridRows && k >= 0 && k < GridCols) begin
        res.row = r[5:0];
        res.column = k[5:0];
        res.glyph = g;
        res.drawn = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cell_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result row=%0d column=%0d", row_o, column_o);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        if (row_o !== e.row) begin
          $error("row expected %0d actual %0d", e.row, row_o); errors++;
        end
        if (column_o !== e.column) begin
          $error("column expected %0d actual %0d", e.column, column_o); errors++;
        end
        if (plot_glyph_o !== e.glyph) begin
          $error("plot_glyph expected %0d actual %0d", e.glyph, plot_glyph_o); errors++;
        end
        if (drawn_o !== e.drawn) begin
          $error("drawn expected %0d actual %0d", e.drawn, drawn_o); errors++;
        end
      end
    end
  end

  task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                            logic [7:0] g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    glyph_i <= g;
    expected_cells = {expected_cells, project_point(px, py, pz, g)};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_angle(cfg_index_e idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_COSINE) cos_q14 = longint'($signed(value));
    else sin_q14 = longint'($signed(value));
  endtask

  task automatic set_angle(logic [15:0] c, logic [15:0] s);
    drain_results();
    write_angle(CFG_COSINE, c);
    write_angle(CFG_SINE, s);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] near_point();
    return 16'($signed($urandom_range(8192)) - 4096);
  endfunction

  task automatic test_directed();
    send_point(16'h0000, 16'h0000, 16'h0000, 8'h2a);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 8'hff);
    send_point(16'h8000, 16'h8000, 16'h8000, 8'h00);
    send_point(16'h0000, 16'h0000, 16'hf000, 8'h41);
    send_point(16'h0000, 16'h0000, 16'he000, 8'h42);
    send_point(16'h0800, 16'hf800, 16'h0000, 8'h55);
    send_point(16'hf001, 16'h0fff, 16'h0000, 8'haa);
    send_point(16'h1000, 16'h1000, 16'h0000, 8'h01);
    set_angle(16'hc000, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h1000, 8'h43);
    send_point(16'h0400, 16'h0400, 16'h0000, 8'h44);
    set_angle(16'h0000, 16'h4000);
    send_point(16'h0400, 16'hfc00, 16'h0200, 8'h45);
    send_point(16'h7fff, 16'h8000, 16'h7fff, 8'h46);
    set_angle(16'h8000, 16'h7fff);
    send_point(16'h0100, 16'h0200, 16'h0300, 8'h47);
    send_point(16'h8000, 16'h7fff, 16'h8000, 8'h48);
    set_angle(16'h2d41, 16'h2d41);
    send_point(16'h0800, 16'h0000, 16'h0800, 8'h49);
  endtask

  task automatic test_random(int count);
    logic [15:0] px, py, pz;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) set_angle(16'($signed($urandom_range(32768)) - 16384),
                                  16'($signed($urandom_range(32768)) - 16384));
      if ($urandom_range(3) == 0) begin
        px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
      end else begin
        px = near_point(); py = near_point(); pz = near_point();
      end
      send_point(px, py, pz, 8'($urandom));
    end
  endtask

  task automatic test_pause_until_drained();
    send_point(16'h0100, 16'h0100, 16'h0100, 8'h50);
    drain_results();
    send_point(16'hff00, 16'hff00, 16'h0100, 8'h51);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 8; recv_stall_pct = 64;
    test_random(650);
    send_idle_pct = 64; recv_stall_pct = 8;
    test_pause_until_drained();
    test_random(650);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(630);
    drain_results();
    set_angle(16'h4000, 16'h0000);
    if (errors == 0 && expected_cells.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
